/* rtl/core/lps_pkg.sv */
// ----------------------------------------------------------------------------
// lps_pkg
// Shared types, constants and helper functions of the LED pattern sequencer.
// ----------------------------------------------------------------------------
package lps_pkg;

    // Default values of the top-level parameters.
    localparam int NUM_KEYS_DEF   = 8;
    localparam int NUM_LEDS_DEF   = 8;
    localparam int TIMER_BITS_DEF = 16;

    // Fixed port widths.
    localparam int PIN_W    = 8;
    localparam int LED_W    = 8;
    localparam int MODE_W   = 2;
    localparam int PERIOD_W = 16;
    localparam int BYTE_W   = 8;
    localparam int APB_AW   = 5;
    localparam int APB_DW   = 32;

    // Depth of the queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;

    // Fixed LED patterns.
    localparam logic [LED_W-1:0] PAT_ALL_ON = 8'hFF;
    localparam logic [LED_W-1:0] PAT_FLASH  = 8'hAA;

    // Register indexes of the configuration port.
    localparam logic [2:0] REG_STARTUP_HOLD    = 3'd0;
    localparam logic [2:0] REG_SWEEP_PERIOD    = 3'd1;
    localparam logic [2:0] REG_FLASH_PERIOD    = 3'd2;
    localparam logic [2:0] REG_COUNT_PERIOD    = 3'd3;
    localparam logic [2:0] REG_DEBOUNCE_PERIOD = 3'd4;
    localparam logic [2:0] REG_ADVANCE_KEYS    = 3'd5;

    // Reset values of the configuration registers.
    localparam logic [PERIOD_W-1:0] RST_STARTUP_HOLD    = 16'd1000;
    localparam logic [PERIOD_W-1:0] RST_SWEEP_PERIOD    = 16'd30;
    localparam logic [PERIOD_W-1:0] RST_FLASH_PERIOD    = 16'd110;
    localparam logic [PERIOD_W-1:0] RST_COUNT_PERIOD    = 16'd1000;
    localparam logic [BYTE_W-1:0]   RST_DEBOUNCE_PERIOD = 8'd10;
    localparam logic [BYTE_W-1:0]   RST_ADVANCE_KEYS    = 8'd1;

    // Output mode codes.
    localparam logic [MODE_W-1:0] MCODE_HOLD  = 2'd0;
    localparam logic [MODE_W-1:0] MCODE_SWEEP = 2'd1;
    localparam logic [MODE_W-1:0] MCODE_FLASH = 2'd2;
    localparam logic [MODE_W-1:0] MCODE_COUNT = 2'd3;

    typedef enum logic [3:0] {
        MODE_HOLD  = 4'b0001,
        MODE_SWEEP = 4'b0010,
        MODE_FLASH = 4'b0100,
        MODE_COUNT = 4'b1000
    } t_mode;

    // One tick as it travels from the front part to the back part.
    typedef struct packed {
        logic [PIN_W-1:0] keys;   // active-high key image, unused keys zero
    } t_item;

    typedef struct packed {
        logic [PERIOD_W-1:0] startup_hold;
        logic [PERIOD_W-1:0] sweep_period;
        logic [PERIOD_W-1:0] flash_period;
        logic [PERIOD_W-1:0] count_period;
        logic [BYTE_W-1:0]   debounce_period;
        logic [BYTE_W-1:0]   advance_keys;
    } t_cfg;

    function automatic logic [MODE_W-1:0] mode_code(input t_mode m);
        logic [MODE_W-1:0] c;
        case (m)
            MODE_HOLD:  c = MCODE_HOLD;
            MODE_SWEEP: c = MCODE_SWEEP;
            MODE_FLASH: c = MCODE_FLASH;
            MODE_COUNT: c = MCODE_COUNT;
            default:    c = MCODE_HOLD;
        endcase
        return c;
    endfunction

endpackage

/* rtl/core/lps_front.sv */
// ----------------------------------------------------------------------------
// lps_front
// Accepts tick transactions, turns the active-low pins into an active-high
// key image and holds the ticks in a short queue for the back part.
// ----------------------------------------------------------------------------
module lps_front #(
    parameter int NUM_KEYS = lps_pkg::NUM_KEYS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [lps_pkg::PIN_W-1:0] i_raw_pins,
    output logic                      o_item_valid,
    input  logic                      i_item_ready,
    output lps_pkg::t_item            o_item
);

    localparam int DEPTH = lps_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [lps_pkg::PIN_W-1:0] KEYS_ALL =
        lps_pkg::PIN_W'((9'd1 << NUM_KEYS) - 9'd1);

    lps_pkg::t_item r_queue [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             push, pop;
    lps_pkg::t_item   item_in;

    assign item_in.keys = ~i_raw_pins & KEYS_ALL;

    assign o_ready      = (r_count != CNT_W'(DEPTH));
    assign o_item_valid = (r_count != '0);
    assign o_item       = r_queue[r_rd_ptr];

    assign push = i_valid && o_ready;
    assign pop  = o_item_valid && i_item_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= item_in;
        end
    end

endmodule

/* rtl/core/lps_back.sv */
// ----------------------------------------------------------------------------
// lps_back
// Runs one tick per cycle unless the output register stalls: vertical-counter debounce,
// phase timer and the mode sequencer, and keeps the result in an output register.
// ----------------------------------------------------------------------------
module lps_back #(
    parameter int NUM_KEYS   = lps_pkg::NUM_KEYS_DEF,
    parameter int NUM_LEDS   = lps_pkg::NUM_LEDS_DEF,
    parameter int TIMER_BITS = lps_pkg::TIMER_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  lps_pkg::t_cfg              i_cfg,
    input  logic                       i_item_valid,
    output logic                       o_item_ready,
    input  lps_pkg::t_item             i_item,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [lps_pkg::LED_W-1:0]  o_led,
    output logic [lps_pkg::MODE_W-1:0] o_mode,
    output logic [lps_pkg::PIN_W-1:0]  o_debounced_keys,
    output logic [lps_pkg::PIN_W-1:0]  o_pending_presses
);

    localparam int CMP_W = (TIMER_BITS > lps_pkg::PERIOD_W) ? TIMER_BITS : lps_pkg::PERIOD_W;
    localparam logic [NUM_LEDS-1:0] LED_TOP   = NUM_LEDS'(1) << (NUM_LEDS - 1);
    localparam logic [NUM_LEDS-1:0] LED_ONE   = NUM_LEDS'(1);
    localparam logic [NUM_LEDS-1:0] PAT_ALL   = lps_pkg::PAT_ALL_ON[NUM_LEDS-1:0];
    localparam logic [NUM_LEDS-1:0] PAT_FLASH = lps_pkg::PAT_FLASH[NUM_LEDS-1:0];

    logic [lps_pkg::BYTE_W-1:0] r_div, n_div;
    logic [NUM_KEYS-1:0]        r_vl, n_vl, r_vh, n_vh;
    logic [NUM_KEYS-1:0]        r_kl, n_kl, r_pl, n_pl;
    lps_pkg::t_mode             r_mode, n_mode;
    logic [NUM_LEDS-1:0]        r_pat, n_pat;
    logic                       r_down, n_down;
    logic                       r_first, n_first;
    logic [TIMER_BITS-1:0]      r_timer, n_timer;

    logic                       r_out_valid;
    logic [lps_pkg::LED_W-1:0]  r_led;
    logic [lps_pkg::MODE_W-1:0] r_mode_code;
    logic [lps_pkg::PIN_W-1:0]  r_keys_out, r_press_out;

    logic                step;
    logic [NUM_KEYS-1:0] pressed, chg, flip, deb_pl, hit, pl_taken;
    logic                take;
    logic [TIMER_BITS-1:0] tmr_inc;
    logic [CMP_W-1:0]    tmr_x;
    logic [NUM_LEDS-1:0] sw_pat;
    logic                sw_down;
    logic [lps_pkg::LED_W-1:0] led_ext;
    logic [lps_pkg::PIN_W-1:0] keys_ext, press_ext;

    assign o_item_ready = !r_out_valid || i_ready;
    assign step         = i_item_valid && o_item_ready;
    assign pressed      = i_item.keys[NUM_KEYS-1:0];

    // Debounce: the divider gates one vertical-counter sample per period.
    always_comb begin
        n_div  = r_div + 1'b1;
        n_vl   = r_vl;
        n_vh   = r_vh;
        n_kl   = r_kl;
        deb_pl = r_pl;
        chg    = '0;
        flip   = '0;
        if (!(n_div < i_cfg.debounce_period)) begin
            n_div  = '0;
            chg    = r_kl ^ pressed;
            n_vl   = ~(r_vl & chg);
            n_vh   = n_vl ^ (r_vh & chg);
            flip   = chg & n_vl & n_vh;
            n_kl   = r_kl ^ flip;
            deb_pl = r_pl | (n_kl & flip);
        end
    end

    assign hit      = deb_pl & i_cfg.advance_keys[NUM_KEYS-1:0];
    assign take     = |hit;
    assign pl_taken = deb_pl & ~hit;

    // The phase timer saturates at its maximum.
    assign tmr_inc = (&r_timer) ? r_timer : r_timer + 1'b1;
    assign tmr_x   = CMP_W'(tmr_inc);

    // Next sweep position; the direction turns at either end.
    always_comb begin
        sw_down = r_down;
        if (!r_down) begin
            sw_pat = {r_pat[NUM_LEDS-2:0], 1'b0};
            if (sw_pat == '0) begin
                sw_pat = LED_TOP;
            end
            if (sw_pat >= LED_TOP) begin
                sw_down = 1'b1;
            end
        end else begin
            sw_pat = r_pat >> 1;
            if (sw_pat <= LED_ONE) begin
                sw_pat  = LED_ONE;
                sw_down = 1'b0;
            end
        end
    end

    always_comb begin
        n_mode  = r_mode;
        n_pat   = r_pat;
        n_down  = r_down;
        n_first = r_first;
        n_timer = tmr_inc;
        n_pl    = deb_pl;
        case (r_mode)
            lps_pkg::MODE_HOLD: begin
                if (tmr_x >= CMP_W'(i_cfg.startup_hold)) begin
                    n_mode  = lps_pkg::MODE_SWEEP;
                    n_pat   = LED_ONE;
                    n_down  = 1'b0;
                    n_first = 1'b1;
                    n_timer = '0;
                end
            end
            lps_pkg::MODE_SWEEP: begin
                if (tmr_x >= CMP_W'(i_cfg.sweep_period)) begin
                    n_timer = '0;
                    if (!r_first && take) begin
                        n_pl    = pl_taken;
                        n_mode  = lps_pkg::MODE_FLASH;
                        n_pat   = PAT_FLASH;
                        n_first = 1'b1;
                    end else begin
                        n_pat   = sw_pat;
                        n_down  = sw_down;
                        n_first = 1'b0;
                    end
                end
            end
            lps_pkg::MODE_FLASH: begin
                if (tmr_x >= CMP_W'(i_cfg.flash_period)) begin
                    n_timer = '0;
                    if (!r_first && take) begin
                        n_pl   = pl_taken;
                        n_mode = lps_pkg::MODE_COUNT;
                        n_pat  = '0;
                    end else begin
                        n_pat   = ~r_pat;
                        n_first = 1'b0;
                    end
                end
            end
            lps_pkg::MODE_COUNT: begin
                // The press check runs every tick and overrides the count step.
                if (tmr_x >= CMP_W'(i_cfg.count_period)) begin
                    n_timer = '0;
                    n_pat   = r_pat + 1'b1;
                end
                if (take) begin
                    n_pl    = pl_taken;
                    n_mode  = lps_pkg::MODE_SWEEP;
                    n_pat   = LED_ONE;
                    n_down  = 1'b0;
                    n_first = 1'b1;
                    n_timer = '0;
                end
            end
            default: begin
                n_mode = lps_pkg::MODE_HOLD;
            end
        endcase
    end

    always_comb begin
        led_ext                  = '0;
        led_ext[NUM_LEDS-1:0]    = n_pat;
        keys_ext                 = '0;
        keys_ext[NUM_KEYS-1:0]   = n_kl;
        press_ext                = '0;
        press_ext[NUM_KEYS-1:0]  = n_pl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div       <= '0;
            r_vl        <= '0;
            r_vh        <= '0;
            r_kl        <= '0;
            r_pl        <= '0;
            r_mode      <= lps_pkg::MODE_HOLD;
            r_pat       <= PAT_ALL;
            r_down      <= 1'b0;
            r_first     <= 1'b1;
            r_timer     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (step) begin
                r_div       <= n_div;
                r_vl        <= n_vl;
                r_vh        <= n_vh;
                r_kl        <= n_kl;
                r_pl        <= n_pl;
                r_mode      <= n_mode;
                r_pat       <= n_pat;
                r_down      <= n_down;
                r_first     <= n_first;
                r_timer     <= n_timer;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_led       <= led_ext;
            r_mode_code <= lps_pkg::mode_code(n_mode);
            r_keys_out  <= keys_ext;
            r_press_out <= press_ext;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_led             = r_led;
    assign o_mode            = r_mode_code;
    assign o_debounced_keys  = r_keys_out;
    assign o_pending_presses = r_press_out;

endmodule

/* rtl/core/led_pattern_sequencer.sv */
// A tick transaction accepted into the queue waits there until the back part
// executes it; its result is then registered in the output register behind o_valid.
// Throughput: one tick per cycle while i_ready stays high; the back part executes each tick whole.
// A two-entry queue and the output register let either side stall on its own.
// Reset (synchronous, active low) restores the configuration and state registers to their defaults,
// sets the pattern to all LEDs on in startup hold mode and empties the queue.
// ----------------------------------------------------------------------------
// led_pattern_sequencer
// LED mode sequencer with vertical-counter key debounce, driven by one
// millisecond tick transaction at a time, with an APB-style register port.
// ----------------------------------------------------------------------------
module led_pattern_sequencer #(
    parameter int NUM_KEYS   = lps_pkg::NUM_KEYS_DEF,
    parameter int NUM_LEDS   = lps_pkg::NUM_LEDS_DEF,
    parameter int TIMER_BITS = lps_pkg::TIMER_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lps_pkg::APB_AW-1:0]  paddr,
    input  logic [lps_pkg::APB_DW-1:0]  pwdata,
    output logic [lps_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [lps_pkg::PIN_W-1:0]   i_raw_pins,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [lps_pkg::LED_W-1:0]   o_led,
    output logic [lps_pkg::MODE_W-1:0]  o_mode,
    output logic [lps_pkg::PIN_W-1:0]   o_debounced_keys,
    output logic [lps_pkg::PIN_W-1:0]   o_pending_presses
);

    lps_pkg::t_cfg  r_cfg;
    lps_pkg::t_item item;
    logic           item_valid, item_ready;
    logic           wr_en;
    logic [2:0]     reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[lps_pkg::APB_AW-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.startup_hold    <= lps_pkg::RST_STARTUP_HOLD;
            r_cfg.sweep_period    <= lps_pkg::RST_SWEEP_PERIOD;
            r_cfg.flash_period    <= lps_pkg::RST_FLASH_PERIOD;
            r_cfg.count_period    <= lps_pkg::RST_COUNT_PERIOD;
            r_cfg.debounce_period <= lps_pkg::RST_DEBOUNCE_PERIOD;
            r_cfg.advance_keys    <= lps_pkg::RST_ADVANCE_KEYS;
        end else if (wr_en) begin
            case (reg_idx)
                lps_pkg::REG_STARTUP_HOLD:
                    r_cfg.startup_hold <= pwdata[lps_pkg::PERIOD_W-1:0];
                lps_pkg::REG_SWEEP_PERIOD:
                    r_cfg.sweep_period <= pwdata[lps_pkg::PERIOD_W-1:0];
                lps_pkg::REG_FLASH_PERIOD:
                    r_cfg.flash_period <= pwdata[lps_pkg::PERIOD_W-1:0];
                lps_pkg::REG_COUNT_PERIOD:
                    r_cfg.count_period <= pwdata[lps_pkg::PERIOD_W-1:0];
                lps_pkg::REG_DEBOUNCE_PERIOD:
                    r_cfg.debounce_period <= pwdata[lps_pkg::BYTE_W-1:0];
                lps_pkg::REG_ADVANCE_KEYS:
                    r_cfg.advance_keys <= pwdata[lps_pkg::BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            lps_pkg::REG_STARTUP_HOLD:    prdata = lps_pkg::APB_DW'(r_cfg.startup_hold);
            lps_pkg::REG_SWEEP_PERIOD:    prdata = lps_pkg::APB_DW'(r_cfg.sweep_period);
            lps_pkg::REG_FLASH_PERIOD:    prdata = lps_pkg::APB_DW'(r_cfg.flash_period);
            lps_pkg::REG_COUNT_PERIOD:    prdata = lps_pkg::APB_DW'(r_cfg.count_period);
            lps_pkg::REG_DEBOUNCE_PERIOD: prdata = lps_pkg::APB_DW'(r_cfg.debounce_period);
            lps_pkg::REG_ADVANCE_KEYS:    prdata = lps_pkg::APB_DW'(r_cfg.advance_keys);
            default:                      prdata = '0;
        endcase
    end

    lps_front #(
        .NUM_KEYS(NUM_KEYS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_raw_pins   (i_raw_pins),
        .o_item_valid (item_valid),
        .i_item_ready (item_ready),
        .o_item       (item)
    );

    lps_back #(
        .NUM_KEYS   (NUM_KEYS),
        .NUM_LEDS   (NUM_LEDS),
        .TIMER_BITS (TIMER_BITS)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (r_cfg),
        .i_item_valid      (item_valid),
        .o_item_ready      (item_ready),
        .i_item            (item),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_led             (o_led),
        .o_mode            (o_mode),
        .o_debounced_keys  (o_debounced_keys),
        .o_pending_presses (o_pending_presses)
    );

endmodule
